// File: design/shared_bus_arbiter_with_priority_queue_core_defines.svh
// assertion macros used by the arbiter control rtl
// no dependencies; define SYNTH to drop the checks
`ifndef SHARED_BUS_ARBITER_WITH_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SHARED_BUS_ARBITER_WITH_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTH
`define SBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sba check failed");
`define SBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sba check failed");
`else
`define SBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/sba_pkg.sv
// types and codes of the shared bus arbiter
// no dependencies
package sba_pkg;

    localparam logic       OP_REQUEST     = 1'b0;
    localparam logic       OP_RESPONSE    = 1'b1;
    localparam logic [7:0] CORE_UNSET     = 8'hFF;
    localparam logic [1:0] PRIORITY_RESET = 2'd3;
    localparam logic       REG_LOCAL_CHIP = 1'b0;
    localparam logic       REG_PRIORITY   = 1'b1;
    localparam logic       PORT_REMOTE    = 1'b0;
    localparam logic       PORT_LOCAL     = 1'b1;

    typedef enum logic [1:0] {
        KIND_QUEUED   = 2'd0,
        KIND_FORWARD  = 2'd1,
        KIND_RESPONSE = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_QUEUE_FULL    = 2'd1,
        ERR_IDLE_RESPONSE = 2'd2
    } err_t;

    typedef struct packed {
        logic [1:0] mgr;
        logic [7:0] tag;
        logic [7:0] dest;
        logic [6:0] core;
    } entry_t;

    typedef struct packed {
        kind_t      kind;
        logic       port;
        logic [1:0] mgr;
        logic [7:0] tag;
        logic [6:0] core;
        err_t       err;
        logic       last;
    } result_t;

endpackage

// File: design/sba_queue_ram.sv
// request queue storage: one write port, one registered read port
// depends on sba_pkg
module sba_queue_ram
    import sba_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int AW          = 3
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem_reg [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/sba_ctrl.sv
// arbitration control: bus owner, queue pointers, result register
// depends on sba_pkg and the assertion macro header
`include "shared_bus_arbiter_with_priority_queue_core_defines.svh"

module sba_ctrl
    import sba_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8,
    parameter int AW          = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    local_chip_id,
    input  logic [1:0]    priority_requester,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          opcode,
    input  logic [1:0]    requester_id,
    input  logic [7:0]    txn_tag,
    input  logic [7:0]    dest_chip,
    input  logic [7:0]    core_tag_in,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       result,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output entry_t        wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  entry_t        rd_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_GRANT = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic          owner_valid_reg, owner_valid_next;
    logic [1:0]    owner_id_reg, owner_id_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          out_free;
    logic          accept;
    entry_t        new_entry;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;

    function automatic result_t fwd_result(entry_t e, logic [7:0] chip, logic fin);
        result_t r;
        r.kind = KIND_FORWARD;
        r.port = (e.dest != chip) ? PORT_REMOTE : PORT_LOCAL;
        r.mgr  = e.mgr;
        r.tag  = e.tag;
        r.core = e.core;
        r.err  = ERR_NONE;
        r.last = fin;
        return r;
    endfunction

    function automatic result_t plain_result(kind_t k, logic [1:0] m, logic [7:0] t,
                                             err_t e, logic fin);
        result_t r;
        r.kind = k;
        r.port = PORT_REMOTE;
        r.mgr  = m;
        r.tag  = t;
        r.core = '0;
        r.err  = e;
        r.last = fin;
        return r;
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // unset core id falls back to the requester
    always_comb
    begin
        new_entry.mgr  = requester_id;
        new_entry.tag  = txn_tag;
        new_entry.dest = dest_chip;
        new_entry.core = (core_tag_in == CORE_UNSET) ? {5'b0, requester_id}
                                                     : core_tag_in[6:0];
    end

    assign tail_sum  = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
    assign tail_addr = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);
    assign head_dec  = (head_reg == '0) ? LAST_ADDR : head_reg - 1'b1;
    assign head_inc  = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        owner_valid_next = owner_valid_reg;
        owner_id_next    = owner_id_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        wr_en            = 1'b0;
        wr_addr          = tail_addr;
        wr_data          = new_entry;
        rd_en            = 1'b0;
        rd_addr          = head_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    if (opcode == OP_REQUEST)
                    begin
                        if (!owner_valid_reg && count_reg == '0)
                        begin
                            out_next         = fwd_result(new_entry, local_chip_id, 1'b1);
                            owner_valid_next = 1'b1;
                            owner_id_next    = requester_id;
                        end
                        else if (count_reg >= DEPTH_CNT)
                        begin
                            out_next = plain_result(KIND_ERROR, requester_id, txn_tag,
                                                    ERR_QUEUE_FULL, 1'b1);
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            if (requester_id == priority_requester)
                            begin
                                wr_addr   = head_dec;
                                head_next = head_dec;
                            end
                            count_next = count_reg + 1'b1;
                            out_next   = plain_result(KIND_QUEUED, requester_id, txn_tag,
                                                      ERR_NONE, 1'b1);
                        end
                    end
                    else if (!owner_valid_reg)
                    begin
                        out_next = plain_result(KIND_ERROR, 2'd0, txn_tag,
                                                ERR_IDLE_RESPONSE, 1'b1);
                    end
                    else
                    begin
                        owner_valid_next = 1'b0;
                        owner_id_next    = 2'd0;
                        if (count_reg == '0)
                        begin
                            out_next = plain_result(KIND_RESPONSE, owner_id_reg, txn_tag,
                                                    ERR_NONE, 1'b1);
                        end
                        else
                        begin
                            out_next   = plain_result(KIND_RESPONSE, owner_id_reg, txn_tag,
                                                      ERR_NONE, 1'b0);
                            rd_en      = 1'b1;
                            head_next  = head_inc;
                            count_next = count_reg - 1'b1;
                            state_next = S_GRANT;
                        end
                    end
                end
            end
            S_GRANT:
            begin
                if (out_free)
                begin
                    out_next         = fwd_result(rd_data, local_chip_id, 1'b1);
                    out_valid_next   = 1'b1;
                    owner_valid_next = 1'b1;
                    owner_id_next    = rd_data.mgr;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            owner_valid_reg <= 1'b0;
            owner_id_reg    <= 2'd0;
            head_reg        <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            owner_valid_reg <= owner_valid_next;
            owner_id_reg    <= owner_id_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    `SBA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)
    `SBA_ASSERT_IMP(a_grant_bus_free, clk, rst_n, state_reg == S_GRANT, !owner_valid_reg)
    `SBA_ASSERT_NXT(a_read_to_grant, clk, rst_n, rd_en, state_reg == S_GRANT)
    `SBA_ASSERT_IMP(a_queued_nonempty, clk, rst_n, out_valid_reg && out_reg.kind == KIND_QUEUED, count_reg != '0)

endmodule

// File: design/shared_bus_arbiter_with_priority_queue_core.sv
// every result appears in the cycle after its request is accepted, from a registered output
// a completion that grants a queued request gives its second result from the S_GRANT state
// once the output is free, paced by the registered read of the queue memory
// one request per cycle while the output is not stalled; no request is taken in S_GRANT
// reset: bus free, queue empty, local_chip_id 0, priority_requester 3;
// queue memory is not cleared
module shared_bus_arbiter_with_priority_queue_core
    import sba_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [1:0]  requester_id,
    input  logic [7:0]  txn_tag,
    input  logic [7:0]  dest_chip,
    input  logic signed [7:0] core_tag_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        route_port,
    output logic [1:0]  manager_out,
    output logic [7:0]  tag_out,
    output logic [6:0]  core_tag_out,
    output logic [1:0]  error_code,
    output logic        last
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [7:0]    local_chip_id_reg;
    logic [1:0]    priority_reg;
    logic          cfg_write;
    result_t       result;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_chip_id_reg <= 8'd0;
            priority_reg      <= PRIORITY_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_LOCAL_CHIP:
                begin
                    local_chip_id_reg <= pwdata[7:0];
                end
                REG_PRIORITY:
                begin
                    priority_reg <= pwdata[1:0];
                end
                default:
                begin
                    priority_reg <= priority_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LOCAL_CHIP: prdata = {24'd0, local_chip_id_reg};
            REG_PRIORITY:   prdata = {30'd0, priority_reg};
            default:        prdata = 32'd0;
        endcase
    end

    sba_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .local_chip_id      (local_chip_id_reg),
        .priority_requester (priority_reg),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .requester_id       (requester_id),
        .txn_tag            (txn_tag),
        .dest_chip          (dest_chip),
        .core_tag_in        ($unsigned(core_tag_in)),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .result             (result),
        .wr_en              (wr_en),
        .wr_addr            (wr_addr),
        .wr_data            (wr_data),
        .rd_en              (rd_en),
        .rd_addr            (rd_addr),
        .rd_data            (rd_data)
    );

    sba_queue_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign kind         = result.kind;
    assign route_port   = result.port;
    assign manager_out  = result.mgr;
    assign tag_out      = result.tag;
    assign core_tag_out = result.core;
    assign error_code   = result.err;
    assign last         = result.last;

endmodule

// File: verif/shared_bus_arbiter_with_priority_queue_core_test.sv
`timescale 1ns / 1ps
// testbench of the shared bus arbiter core: directed and random requests, checked against
// an in-bench model of bus ownership, head/tail queueing and chip routing
// depends on sba_pkg and the arbiter core rtl only
module shared_bus_arbiter_with_priority_queue_core_test
    import sba_pkg::*;
();

    localparam int QUEUE_SLOTS = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 24;
    localparam int REPORT_LIMIT = 10;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = 3'd0;
    logic [31:0]       pwdata = 32'd0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              opcode = OP_REQUEST;
    logic [1:0]        requester_id = 2'd0;
    logic [7:0]        txn_tag = 8'd0;
    logic [7:0]        dest_chip = 8'd0;
    logic signed [7:0] core_tag_in = 8'sd0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        kind;
    logic              route_port;
    logic [1:0]        manager_out;
    logic [7:0]        tag_out;
    logic [6:0]        core_tag_out;
    logic [1:0]        error_code;
    logic              last;

    // model of the arbiter
    logic [7:0] local_chip = 8'd0;
    logic [1:0] priority_mgr = PRIORITY_RESET;
    logic       bus_owned = 1'b0;
    logic [1:0] bus_owner = 2'd0;
    entry_t     waiting_requests[$];
    result_t    arbiter_results_due[$];

    bit steady = 1'b0;
    int hold_off_left = 0;
    int mismatches = 0;

    shared_bus_arbiter_with_priority_queue_core #(.QUEUE_DEPTH(QUEUE_SLOTS)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t make_result(kind_t k, logic port, logic [1:0] mgr,
            logic [7:0] tag, logic [6:0] core, err_t err, logic fin);
        result_t r;
        r.kind = k;
        r.port = port;
        r.mgr = mgr;
        r.tag = tag;
        r.core = core;
        r.err = err;
        r.last = fin;
        return r;
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("kind %0d port %0d mgr %0d tag %0d core %0d err %0d last %0d",
                         r.kind, r.port, r.mgr, r.tag, r.core, r.err, r.last);
    endfunction

    function automatic void add_due(result_t r);
        arbiter_results_due.insert(arbiter_results_due.size(), r);
    endfunction

    function automatic void grant_bus(entry_t e);
        bus_owned = 1'b1;
        bus_owner = e.mgr;
        add_due(make_result(KIND_FORWARD,
            (e.dest != local_chip) ? PORT_REMOTE : PORT_LOCAL,
            e.mgr, e.tag, e.core, ERR_NONE, 1'b1));
    endfunction

    function automatic void arbitrate(logic op, logic [1:0] req, logic [7:0] tag,
            logic [7:0] dest, logic [7:0] core);
        entry_t     e;
        logic [1:0] owner;
        e.mgr = req;
        e.tag = tag;
        e.dest = dest;
        e.core = (core == CORE_UNSET) ? 7'(req) : core[6:0];
        if (op == OP_REQUEST)
        begin
            if (!bus_owned && waiting_requests.size() == 0)
                grant_bus(e);
            else if (waiting_requests.size() >= QUEUE_SLOTS)
                add_due(make_result(KIND_ERROR, PORT_REMOTE, req, tag,
                                    7'd0, ERR_QUEUE_FULL, 1'b1));
            else
            begin
                if (req == priority_mgr)
                    waiting_requests.insert(0, e);
                else
                    waiting_requests.insert(waiting_requests.size(), e);
                add_due(make_result(KIND_QUEUED, PORT_REMOTE, req, tag,
                                    7'd0, ERR_NONE, 1'b1));
            end
        end
        else if (!bus_owned)
            add_due(make_result(KIND_ERROR, PORT_REMOTE, 2'd0, tag,
                                7'd0, ERR_IDLE_RESPONSE, 1'b1));
        else
        begin
            owner = bus_owner;
            bus_owned = 1'b0;
            bus_owner = 2'd0;
            add_due(make_result(KIND_RESPONSE, PORT_REMOTE, owner, tag,
                                7'd0, ERR_NONE, waiting_requests.size() == 0));
            if (waiting_requests.size() != 0)
            begin
                grant_bus(waiting_requests[0]);
                waiting_requests.delete(0);
            end
        end
    endfunction

    task automatic send_item(logic op, logic [1:0] req, logic [7:0] tag, logic [7:0] dest,
            logic [7:0] core);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        requester_id <= req;
        txn_tag <= tag;
        dest_chip <= dest;
        core_tag_in <= core;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        arbitrate(op, req, tag, dest, core);
        @(negedge clk);
    endtask

    task automatic send_random_item(int req_pct);
        logic       op;
        logic [7:0] dest;
        logic [7:0] core;
        op = ($urandom_range(99) < req_pct) ? OP_REQUEST : OP_RESPONSE;
        dest = $urandom_range(1) ? local_chip : 8'($urandom_range(255));
        core = ($urandom_range(99) < 30) ? CORE_UNSET : 8'($urandom_range(255));
        send_item(op, 2'($urandom_range(3)), 8'($urandom_range(255)), dest, core);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_LOCAL_CHIP)
            local_chip = value[7:0];
        else
            priority_mgr = value[1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (arbiter_results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_idle_response_and_direct_grant();
        send_item(OP_RESPONSE, 2'd2, 8'hA5, 8'd0, 8'd0);
        send_item(OP_REQUEST, 2'd0, 8'd0, 8'd0, CORE_UNSET);
        send_item(OP_RESPONSE, 2'd1, 8'd255, 8'd255, 8'd127);
    endtask

    task automatic test_queue_fill_priority_and_drain();
        logic [7:0] core;
        send_item(OP_REQUEST, 2'd3, 8'd255, 8'd255, 8'd127);
        for (int i = 0; i < QUEUE_SLOTS; i++)
        begin
            case (i % 4)
                0: core = 8'h80;
                1: core = CORE_UNSET;
                2: core = 8'hFE;
                default: core = 8'(i * 16);
            endcase
            send_item(OP_REQUEST, 2'(i * 3), 8'(i * 36 + 1), i[0] ? 8'd255 : local_chip, core);
        end
        send_item(OP_REQUEST, 2'd3, 8'd0, 8'd0, CORE_UNSET);
        send_item(OP_REQUEST, 2'd1, 8'd77, 8'd255, 8'd3);
        repeat (QUEUE_SLOTS + 1)
            send_item(OP_RESPONSE, 2'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic test_random_traffic(int count, int req_pct, logic [7:0] chip,
            logic [1:0] prio, bit no_idle);
        wait_idle();
        write_reg(REG_LOCAL_CHIP, 32'(chip));
        write_reg(REG_PRIORITY, 32'(prio));
        steady = no_idle;
        repeat (count)
            send_random_item(req_pct);
        steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_off_left = 300;
        repeat (40)
            send_random_item(60);
    endtask

    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_ready <= 1'b0;
            hold_off_left--;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin : check_results
        result_t seen;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.kind = kind_t'(kind);
            seen.port = route_port;
            seen.mgr = manager_out;
            seen.tag = tag_out;
            seen.core = core_tag_out;
            seen.err = err_t'(error_code);
            seen.last = last;
            if (arbiter_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: %s", describe(seen));
            end
            else
            begin
                want = arbiter_results_due[0];
                arbiter_results_due.delete(0);
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: expected %s, got %s", describe(want),
                                 describe(seen));
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_idle_response_and_direct_grant();
        test_queue_fill_priority_and_drain();
        test_random_traffic(250, 55, 8'd255, 2'd0, 1'b0);
        test_random_traffic(150, 50, 8'd1, 2'd1, 1'b1);
        test_output_backpressure();
        test_random_traffic(250, 65, 8'($urandom_range(255)), 2'd2, 1'b0);
        test_random_traffic(300, 45, 8'd0, 2'd3, 1'b0);
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
